[sv/ordered_list_table_assert.svh]
// Assertion macros used by the ordered list table datapath.
`ifndef ORDERED_LIST_TABLE_ASSERT_SVH
`define ORDERED_LIST_TABLE_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Property that must hold at every clock edge outside reset.
`define OLT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define OLT_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`else

`define OLT_ASSERT(label, prop, msg)
`define OLT_ASSERT_IMPL(label, ante, cons, msg)

`endif

`endif

[sv/olt_pkg.sv]
// Package with constants, codes and control structs of the ordered list table.
package olt_pkg;

  localparam int CAPACITY    = 16;
  localparam int CNT_W       = $clog2(CAPACITY + 1);
  localparam int ADDR_W      = $clog2(CAPACITY);
  localparam int VALUE_W     = 32;
  localparam int MODE_W      = 3;
  localparam int STATUS_W    = 3;
  localparam int COUNT_W     = 5;
  localparam int OUT_TDATA_W = ((VALUE_W + COUNT_W + 7) / 8) * 8;

  typedef enum logic [MODE_W-1:0] {
    MODE_PUSH_HEAD = 3'd0,
    MODE_PUSH_TAIL = 3'd1,
    MODE_INSERT    = 3'd2,
    MODE_DELETE    = 3'd3,
    MODE_POP_HEAD  = 3'd4,
    MODE_SWAP_ENDS = 3'd5
  } mode_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_EMPTY    = 3'd1,
    ST_NOTFOUND = 3'd2,
    ST_FULL     = 3'd3,
    ST_BADMODE  = 3'd4
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_SCAN_CHK,
    S_SCAN_EV,
    S_UP_CHK,
    S_UP_WR,
    S_POP_EV,
    S_DN_CHK,
    S_DN_WR,
    S_SW_RD1,
    S_SW_WR0,
    S_SW_WR1,
    S_DONE
  } state_e;

  typedef enum logic [2:0] {
    IDX_HOLD, IDX_ZERO, IDX_CNT, IDX_INC, IDX_DEC
  } idx_op_e;

  typedef enum logic [1:0] {
    POS_HOLD, POS_ZERO, POS_CNT, POS_IDX
  } pos_op_e;

  typedef enum logic [2:0] {
    RA_IDX, RA_IDX_DN, RA_IDX_UP, RA_HEAD, RA_LAST
  } rd_addr_e;

  typedef enum logic [1:0] {
    WA_IDX, WA_HEAD, WA_LAST
  } wr_addr_e;

  typedef enum logic [1:0] {
    WD_RD, WD_VAL, WD_HOLD
  } wr_data_e;

  typedef enum logic [1:0] {
    CNT_HOLD, CNT_INC, CNT_DEC
  } cnt_op_e;

  typedef struct packed {
    logic     load_req;
    idx_op_e  idx_op;
    pos_op_e  pos_op;
    logic     rd_en;
    rd_addr_e rd_addr;
    logic     wr_en;
    wr_addr_e wr_addr;
    wr_data_e wr_data;
    logic     hold_load;
    cnt_op_e  cnt_op;
    logic     out_load;
    status_e  status;
    logic     rem_sel;
  } olt_cmd_t;

  typedef struct packed {
    mode_e mode;
    logic  cnt_zero;
    logic  cnt_full;
    logic  idx_is_cnt;
    logic  idx_is_pos;
    logic  idx_is_last;
    logic  rd_gt;
    logic  rd_eq;
    logic  out_busy;
  } olt_stat_t;

endpackage

[sv/ordered_list_table.sv]
// Top level of the ordered list table: request stream in, one result per request out.
// One request at a time: the next request is taken in the cycle after the result is loaded.
// Reset (rst_ni low, asynchronous) empties the list; entry contents are not cleared.
module ordered_list_table
  import olt_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // Request channel.
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  input  logic [VALUE_W-1:0]     s_axis_tdata_i,   // [31:0] value
  input  logic [MODE_W-1:0]      s_axis_tuser_i,   // [2:0] mode
  // Result channel.
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata_o,   // [31:0] removed_value, [36:32] entry_count
  output logic [STATUS_W-1:0]    m_axis_tuser_o    // [2:0] status
);

  // The controller sequences each request through scan and shift loops; the
  // datapath holds the entry memory, the pointers, the count and the result
  // register. The result register lets a new request be taken while the
  // previous result still waits on the result channel. The shift loops move
  // one entry per pass through their check and write states, and a result
  // still held back only delays the final load of the next result.
  olt_cmd_t  cmd;
  olt_stat_t stat;

  olt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid_i),
    .s_tready_o (s_axis_tready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  olt_dpath u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tdata_i  (s_axis_tdata_i),
    .s_tuser_i  (s_axis_tuser_i),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .m_tvalid_o (m_axis_tvalid_o),
    .m_tready_i (m_axis_tready_i),
    .m_tdata_o  (m_axis_tdata_o),
    .m_tuser_o  (m_axis_tuser_o)
  );

endmodule

[sv/olt_dpath.sv]
// Datapath of the ordered list table: entry memory, pointers, count and result register.
module olt_dpath
  import olt_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic [VALUE_W-1:0]     s_tdata_i,
  input  logic [MODE_W-1:0]      s_tuser_i,
  input  olt_cmd_t               cmd_i,
  output olt_stat_t              stat_o,
  output logic                   m_tvalid_o,
  input  logic                   m_tready_i,
  output logic [OUT_TDATA_W-1:0] m_tdata_o,
  output logic [STATUS_W-1:0]    m_tuser_o
);

  logic [VALUE_W-1:0] mem [CAPACITY];
  logic [VALUE_W-1:0] rd_data_q;
  logic [VALUE_W-1:0] val_q, hold_q;
  mode_e              mode_q;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [CNT_W-1:0]   idx_q, idx_d;
  logic [CNT_W-1:0]   pos_q, pos_d;
  logic [CNT_W-1:0]   idx_dn, idx_up, cnt_last;
  logic [ADDR_W-1:0]  rd_addr, wr_addr;
  logic [VALUE_W-1:0] wr_data;

  logic                out_valid_q, out_valid_d;
  status_e             out_status_q;
  logic [VALUE_W-1:0]  out_removed_q;
  logic [COUNT_W-1:0]  out_count_q;

  assign idx_dn   = idx_q - CNT_W'(1);
  assign idx_up   = idx_q + CNT_W'(1);
  assign cnt_last = cnt_q - CNT_W'(1);

  always_comb begin
    case (cmd_i.rd_addr)
      RA_IDX:    rd_addr = idx_q[ADDR_W-1:0];
      RA_IDX_DN: rd_addr = idx_dn[ADDR_W-1:0];
      RA_IDX_UP: rd_addr = idx_up[ADDR_W-1:0];
      RA_HEAD:   rd_addr = '0;
      RA_LAST:   rd_addr = cnt_last[ADDR_W-1:0];
      default:   rd_addr = idx_q[ADDR_W-1:0];
    endcase
    case (cmd_i.wr_addr)
      WA_IDX:  wr_addr = idx_q[ADDR_W-1:0];
      WA_HEAD: wr_addr = '0;
      WA_LAST: wr_addr = cnt_last[ADDR_W-1:0];
      default: wr_addr = idx_q[ADDR_W-1:0];
    endcase
    case (cmd_i.wr_data)
      WD_RD:   wr_data = rd_data_q;
      WD_VAL:  wr_data = val_q;
      WD_HOLD: wr_data = hold_q;
      default: wr_data = rd_data_q;
    endcase
  end

  // Entry memory: one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd_i.rd_en) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      val_q  <= s_tdata_i;
      mode_q <= mode_e'(s_tuser_i);
    end
    if (cmd_i.hold_load) begin
      hold_q <= rd_data_q;
    end
    if (cmd_i.out_load) begin
      out_status_q  <= cmd_i.status;
      out_removed_q <= cmd_i.rem_sel ? hold_q : '0;
      out_count_q   <= COUNT_W'(cnt_q);
    end
  end

  always_comb begin
    case (cmd_i.idx_op)
      IDX_HOLD: idx_d = idx_q;
      IDX_ZERO: idx_d = '0;
      IDX_CNT:  idx_d = cnt_q;
      IDX_INC:  idx_d = idx_up;
      IDX_DEC:  idx_d = idx_dn;
      default:  idx_d = idx_q;
    endcase
    case (cmd_i.pos_op)
      POS_HOLD: pos_d = pos_q;
      POS_ZERO: pos_d = '0;
      POS_CNT:  pos_d = cnt_q;
      POS_IDX:  pos_d = idx_q;
      default:  pos_d = pos_q;
    endcase
    case (cmd_i.cnt_op)
      CNT_HOLD: cnt_d = cnt_q;
      CNT_INC:  cnt_d = cnt_q + CNT_W'(1);
      CNT_DEC:  cnt_d = cnt_last;
      default:  cnt_d = cnt_q;
    endcase
    if (cmd_i.out_load) begin
      out_valid_d = 1'b1;
    end else if (m_tready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      idx_q       <= '0;
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      idx_q       <= idx_d;
      pos_q       <= pos_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    stat_o.mode        = mode_q;
    stat_o.cnt_zero    = (cnt_q == '0);
    stat_o.cnt_full    = (cnt_q >= CNT_W'(CAPACITY));
    stat_o.idx_is_cnt  = (idx_q == cnt_q);
    stat_o.idx_is_pos  = (idx_q == pos_q);
    stat_o.idx_is_last = (idx_up == cnt_q);
    stat_o.rd_gt       = ($signed(rd_data_q) > $signed(val_q));
    stat_o.rd_eq       = (rd_data_q == val_q);
    stat_o.out_busy    = out_valid_q && !m_tready_i;
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tuser_o  = out_status_q;
  assign m_tdata_o  = {{(OUT_TDATA_W - VALUE_W - COUNT_W){1'b0}}, out_count_q, out_removed_q};

  `include "ordered_list_table_assert.svh"

  `OLT_ASSERT(a_cnt_bound, cnt_q <= CNT_W'(CAPACITY), "entry count above capacity")
  `OLT_ASSERT_IMPL(a_full_status, cmd_i.out_load && cmd_i.status == ST_FULL, cnt_q == CNT_W'(CAPACITY), "full status with room left")
  `OLT_ASSERT_IMPL(a_empty_status, cmd_i.out_load && cmd_i.status == ST_EMPTY, cnt_q == '0, "empty status on a non-empty list")
  `OLT_ASSERT_IMPL(a_cnt_step, cnt_q != $past(cnt_q), cnt_q == $past(cnt_q) + CNT_W'(1) || cnt_q + CNT_W'(1) == $past(cnt_q), "entry count moved by more than one")

endmodule

[sv/olt_ctrl.sv]
// Controller state machine of the ordered list table.
module olt_ctrl
  import olt_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      s_tvalid_i,
  output logic      s_tready_o,
  input  olt_stat_t stat_i,
  output olt_cmd_t  cmd_o
);

  state_e  state_q, state_d;
  status_e st_q, st_d;
  logic    rem_q, rem_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      st_q    <= ST_OK;
      rem_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      st_q    <= st_d;
      rem_q   <= rem_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    st_d       = st_q;
    rem_d      = rem_q;
    s_tready_o = 1'b0;
    cmd_o      = '{
      load_req:  1'b0,
      idx_op:    IDX_HOLD,
      pos_op:    POS_HOLD,
      rd_en:     1'b0,
      rd_addr:   RA_IDX,
      wr_en:     1'b0,
      wr_addr:   WA_IDX,
      wr_data:   WD_RD,
      hold_load: 1'b0,
      cnt_op:    CNT_HOLD,
      out_load:  1'b0,
      status:    st_q,
      rem_sel:   rem_q
    };

    case (state_q)
      S_IDLE: begin
        s_tready_o     = 1'b1;
        cmd_o.load_req = s_tvalid_i;
        if (s_tvalid_i) begin
          st_d    = ST_OK;
          rem_d   = 1'b0;
          state_d = S_DISPATCH;
        end
      end

      S_DISPATCH: begin
        case (stat_i.mode)
          MODE_PUSH_HEAD, MODE_PUSH_TAIL, MODE_INSERT: begin
            if (stat_i.cnt_full) begin
              st_d    = ST_FULL;
              state_d = S_DONE;
            end else if (stat_i.mode == MODE_PUSH_HEAD) begin
              cmd_o.pos_op = POS_ZERO;
              cmd_o.idx_op = IDX_CNT;
              state_d      = S_UP_CHK;
            end else if (stat_i.mode == MODE_PUSH_TAIL) begin
              cmd_o.pos_op = POS_CNT;
              cmd_o.idx_op = IDX_CNT;
              state_d      = S_UP_CHK;
            end else begin
              cmd_o.idx_op = IDX_ZERO;
              state_d      = S_SCAN_CHK;
            end
          end
          MODE_DELETE: begin
            if (stat_i.cnt_zero) begin
              st_d    = ST_EMPTY;
              state_d = S_DONE;
            end else begin
              cmd_o.idx_op = IDX_ZERO;
              state_d      = S_SCAN_CHK;
            end
          end
          MODE_POP_HEAD: begin
            if (stat_i.cnt_zero) begin
              st_d    = ST_EMPTY;
              state_d = S_DONE;
            end else begin
              cmd_o.rd_en   = 1'b1;
              cmd_o.rd_addr = RA_HEAD;
              cmd_o.idx_op  = IDX_ZERO;
              state_d       = S_POP_EV;
            end
          end
          MODE_SWAP_ENDS: begin
            if (stat_i.cnt_zero) begin
              st_d    = ST_EMPTY;
              state_d = S_DONE;
            end else begin
              cmd_o.rd_en   = 1'b1;
              cmd_o.rd_addr = RA_HEAD;
              state_d       = S_SW_RD1;
            end
          end
          default: begin
            st_d    = ST_BADMODE;
            state_d = S_DONE;
          end
        endcase
      end

      // Walk the list until the insert point, the matching entry or the end of the list.
      S_SCAN_CHK: begin
        if (stat_i.idx_is_cnt) begin
          if (stat_i.mode == MODE_INSERT) begin
            cmd_o.pos_op = POS_IDX;
            cmd_o.idx_op = IDX_CNT;
            state_d      = S_UP_CHK;
          end else begin
            st_d    = ST_NOTFOUND;
            state_d = S_DONE;
          end
        end else begin
          cmd_o.rd_en   = 1'b1;
          cmd_o.rd_addr = RA_IDX;
          state_d       = S_SCAN_EV;
        end
      end

      S_SCAN_EV: begin
        if (stat_i.mode == MODE_INSERT) begin
          if (stat_i.rd_gt) begin
            cmd_o.idx_op = IDX_INC;
            state_d      = S_SCAN_CHK;
          end else begin
            cmd_o.pos_op = POS_IDX;
            cmd_o.idx_op = IDX_CNT;
            state_d      = S_UP_CHK;
          end
        end else if (stat_i.rd_eq) begin
          cmd_o.hold_load = 1'b1;
          rem_d           = 1'b1;
          state_d         = S_DN_CHK;
        end else begin
          cmd_o.idx_op = IDX_INC;
          state_d      = S_SCAN_CHK;
        end
      end

      // Shift entries up by one until the slot at the insert point is open.
      S_UP_CHK: begin
        if (stat_i.idx_is_pos) begin
          cmd_o.wr_en   = 1'b1;
          cmd_o.wr_addr = WA_IDX;
          cmd_o.wr_data = WD_VAL;
          cmd_o.cnt_op  = CNT_INC;
          state_d       = S_DONE;
        end else begin
          cmd_o.rd_en   = 1'b1;
          cmd_o.rd_addr = RA_IDX_DN;
          state_d       = S_UP_WR;
        end
      end

      S_UP_WR: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.wr_addr = WA_IDX;
        cmd_o.wr_data = WD_RD;
        cmd_o.idx_op  = IDX_DEC;
        state_d       = S_UP_CHK;
      end

      S_POP_EV: begin
        cmd_o.hold_load = 1'b1;
        rem_d           = 1'b1;
        state_d         = S_DN_CHK;
      end

      // Shift entries down by one to close the removed slot.
      S_DN_CHK: begin
        if (stat_i.idx_is_last) begin
          cmd_o.cnt_op = CNT_DEC;
          state_d      = S_DONE;
        end else begin
          cmd_o.rd_en   = 1'b1;
          cmd_o.rd_addr = RA_IDX_UP;
          state_d       = S_DN_WR;
        end
      end

      S_DN_WR: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.wr_addr = WA_IDX;
        cmd_o.wr_data = WD_RD;
        cmd_o.idx_op  = IDX_INC;
        state_d       = S_DN_CHK;
      end

      S_SW_RD1: begin
        cmd_o.hold_load = 1'b1;
        cmd_o.rd_en     = 1'b1;
        cmd_o.rd_addr   = RA_LAST;
        state_d         = S_SW_WR0;
      end

      S_SW_WR0: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.wr_addr = WA_HEAD;
        cmd_o.wr_data = WD_RD;
        state_d       = S_SW_WR1;
      end

      S_SW_WR1: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.wr_addr = WA_LAST;
        cmd_o.wr_data = WD_HOLD;
        state_d       = S_DONE;
      end

      S_DONE: begin
        if (!stat_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

[tb/sv/ordered_list_table_tb.sv]
// Self-checking testbench for the ordered list table: directed and random list requests.
`timescale 1ns / 1ps

module ordered_list_table_tb;
  import olt_pkg::*;

  // Mode codes outside the defined operations; the block must answer them with a bad-mode status.
  localparam logic [MODE_W-1:0] MODE_BAD_LO = 3'd6;
  localparam logic [MODE_W-1:0] MODE_BAD_HI = 3'd7;

  // Longest request is an insert into a nearly full list.
  localparam int DRAIN_CYCLES = 4 * CAPACITY + 40;

  typedef struct {
    logic [MODE_W-1:0]  mode;
    logic [VALUE_W-1:0] value;
  } list_req_t;

  typedef struct {
    status_e            status;
    logic [VALUE_W-1:0] removed;
    logic [COUNT_W-1:0] count;
  } list_reply_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid_i = 1'b0;
  logic                   s_axis_tready_o;
  logic [VALUE_W-1:0]     s_axis_tdata_i = '0;
  logic [MODE_W-1:0]      s_axis_tuser_i = '0;
  logic                   m_axis_tvalid_o;
  logic                   m_axis_tready_i = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata_o;
  logic [STATUS_W-1:0]    m_axis_tuser_o;

  // Shadow copy of the list, head at index 0.
  logic [VALUE_W-1:0] shadow_list[$];

  list_req_t   requests_q[$];
  list_reply_t replies_due_q[$];

  int  requests_queued = 0;
  int  replies_seen    = 0;
  int  fail_count      = 0;
  int  send_idle_pct   = 0;
  int  recv_stall_pct  = 0;
  logic req_taken      = 1'b0;

  ordered_list_table i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Applies one request to the shadow list and returns the reply the block owes for it.
  function automatic list_reply_t apply_list_request(logic [MODE_W-1:0] mode,
                                                     logic [VALUE_W-1:0] value);
    list_reply_t rep;
    logic [VALUE_W-1:0] held;
    int pos;
    rep.status  = ST_OK;
    rep.removed = '0;
    case (mode)
      MODE_PUSH_HEAD, MODE_PUSH_TAIL, MODE_INSERT: begin
        if (shadow_list.size() >= CAPACITY) begin
          rep.status = ST_FULL;
        end else if (mode == MODE_PUSH_HEAD) begin
          shadow_list.push_front(value);
        end else if (mode == MODE_PUSH_TAIL) begin
          shadow_list.push_back(value);
        end else begin
          // Descending order: the new value lands before the first entry not greater than it.
          pos = 0;
          while (pos < shadow_list.size() && $signed(shadow_list[pos]) > $signed(value))
            pos++;
          shadow_list.insert(pos, value);
        end
      end
      MODE_DELETE: begin
        if (shadow_list.size() == 0) begin
          rep.status = ST_EMPTY;
        end else begin
          pos = 0;
          while (pos < shadow_list.size() && shadow_list[pos] != value)
            pos++;
          if (pos >= shadow_list.size()) begin
            rep.status = ST_NOTFOUND;
          end else begin
            rep.removed = shadow_list[pos];
            shadow_list.delete(pos);
          end
        end
      end
      MODE_POP_HEAD: begin
        if (shadow_list.size() == 0) begin
          rep.status = ST_EMPTY;
        end else begin
          rep.removed = shadow_list.pop_front();
        end
      end
      MODE_SWAP_ENDS: begin
        if (shadow_list.size() == 0) begin
          rep.status = ST_EMPTY;
        end else begin
          held = shadow_list[0];
          shadow_list[0] = shadow_list[shadow_list.size() - 1];
          shadow_list[shadow_list.size() - 1] = held;
        end
      end
      default: begin
        rep.status = ST_BADMODE;
      end
    endcase
    rep.count = COUNT_W'(shadow_list.size());
    return rep;
  endfunction

  task automatic queue_request(logic [MODE_W-1:0] mode, logic [VALUE_W-1:0] value);
    list_req_t req;
    req.mode  = mode;
    req.value = value;
    requests_q.push_back(req);
    requests_queued++;
  endtask

  // Half the time a small pool of values so that deletes find their target and inserts see ties;
  // the extremes and fully random words keep every bit of the field moving.
  function automatic logic [VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2, 3, 4,
      5, 6:    return 32'($urandom_range(0, 9)) - 32'd5;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [MODE_W-1:0] pick_push_mode();
    case ($urandom_range(0, 3))
      0:       return MODE_PUSH_HEAD;
      1:       return MODE_PUSH_TAIL;
      default: return MODE_INSERT;
    endcase
  endfunction

  function automatic logic [MODE_W-1:0] pick_any_mode();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 40)      return pick_push_mode();
    else if (roll < 62) return MODE_DELETE;
    else if (roll < 78) return MODE_POP_HEAD;
    else if (roll < 93) return MODE_SWAP_ENDS;
    else if (roll < 96) return MODE_BAD_LO;
    else                return MODE_BAD_HI;
  endfunction

  // Random traffic built from bursts: fill runs that push the list past full, drain runs
  // that empty it again, and mixed runs of every operation.
  task automatic queue_random_traffic(int target);
    int added;
    int run_len;
    int shape;
    added = 0;
    // Start with a fill run so that the full-list rejection is reached early.
    shape = 0;
    while (added < target) begin
      run_len = $urandom_range(18, 22);
      for (int k = 0; k < run_len; k++) begin
        case (shape)
          0:       queue_request(pick_push_mode(), pick_value());
          1:       queue_request(($urandom_range(0, 1) == 0) ? MODE_POP_HEAD : MODE_DELETE,
                                 pick_value());
          default: queue_request(pick_any_mode(), pick_value());
        endcase
      end
      added += run_len;
      shape = $urandom_range(0, 3);
    end
  endtask

  // Short directed opener: the empty-list answers, bad modes, the lone-entry delete and swap,
  // the value extremes, ties on insert and a miss on delete.
  task automatic queue_directed();
    queue_request(MODE_POP_HEAD,  32'h0000_0000);
    queue_request(MODE_DELETE,    32'h0000_0000);
    queue_request(MODE_SWAP_ENDS, 32'h0000_0000);
    queue_request(MODE_BAD_LO,    32'h1234_5678);
    queue_request(MODE_BAD_HI,    32'hffff_ffff);
    queue_request(MODE_PUSH_TAIL, 32'd5);
    queue_request(MODE_DELETE,    32'd9);
    queue_request(MODE_SWAP_ENDS, 32'd0);
    queue_request(MODE_DELETE,    32'd5);
    queue_request(MODE_PUSH_HEAD, 32'h8000_0000);
    queue_request(MODE_PUSH_TAIL, 32'h7fff_ffff);
    queue_request(MODE_INSERT,    32'h0000_0000);
    queue_request(MODE_INSERT,    32'h0000_0000);
    queue_request(MODE_INSERT,    32'hffff_ffff);
    queue_request(MODE_INSERT,    32'h7fff_ffff);
    queue_request(MODE_INSERT,    32'h8000_0000);
    queue_request(MODE_SWAP_ENDS, 32'd0);
    queue_request(MODE_DELETE,    32'd1234);
    queue_request(MODE_DELETE,    32'h0000_0000);
    queue_request(MODE_DELETE,    32'h8000_0000);
    queue_request(MODE_POP_HEAD,  32'hffff_ffff);
    queue_request(MODE_BAD_LO,    32'h0000_0000);
  endtask

  // Request driver: a new request is offered only once the previous one has been taken.
  always @(negedge clk_i) begin : drive_requests
    list_req_t nxt;
    if (rst_ni && (!s_axis_tvalid_i || req_taken)) begin
      if (requests_q.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        nxt = requests_q.pop_front();
        s_axis_tvalid_i <= 1'b1;
        s_axis_tuser_i  <= nxt.mode;
        s_axis_tdata_i  <= nxt.value;
      end else begin
        s_axis_tvalid_i <= 1'b0;
      end
    end
  end

  // Result receiver back-pressure.
  always @(negedge clk_i) begin : drive_result_ready
    m_axis_tready_i <= rst_ni && ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Both handshakes are observed at the rising edge. A taken request is predicted right away;
  // each result is matched against the oldest reply still owed.
  always @(posedge clk_i) begin : watch_handshakes
    list_reply_t want;
    if (rst_ni) begin
      req_taken <= s_axis_tvalid_i && s_axis_tready_o;
      if (s_axis_tvalid_i && s_axis_tready_o)
        replies_due_q.push_back(apply_list_request(s_axis_tuser_i, s_axis_tdata_i));
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        replies_seen++;
        if (replies_due_q.size() == 0) begin
          $error("result with no request outstanding: status %0d", m_axis_tuser_o);
          fail_count++;
        end else begin
          want = replies_due_q.pop_front();
          if (m_axis_tuser_o !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, m_axis_tuser_o);
            fail_count++;
          end
          if (m_axis_tdata_o[VALUE_W-1:0] !== want.removed) begin
            $error("removed_value: expected %0d, got %0d",
                   $signed(want.removed), $signed(m_axis_tdata_o[VALUE_W-1:0]));
            fail_count++;
          end
          if (m_axis_tdata_o[VALUE_W +: COUNT_W] !== want.count) begin
            $error("entry_count: expected %0d, got %0d",
                   want.count, m_axis_tdata_o[VALUE_W +: COUNT_W]);
            fail_count++;
          end
        end
      end
    end
  end

  // Main sequence: reset, then four pacing phases, each run until every reply is back.
  initial begin : run_phases
    int idle_by_phase[4];
    int stall_by_phase[4];
    idle_by_phase  = '{0, 46, 0, 26};
    stall_by_phase = '{0, 0, 46, 26};
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = idle_by_phase[ph];
      recv_stall_pct = stall_by_phase[ph];
      if (ph == 0)
        queue_directed();
      queue_random_traffic(330);
      do @(negedge clk_i); while (replies_seen != requests_queued);
    end
    // Let any stray result surface before the verdict.
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Watchdog far beyond the slowest legal run.
  initial begin : watchdog
    #20_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
